>>> rtl/core/nearest_reference_color_classifier_defines.svh
// Assertion macros used by the checker file.
`ifndef NEAREST_REFERENCE_COLOR_CLASSIFIER_DEFINES_SVH
`define NEAREST_REFERENCE_COLOR_CLASSIFIER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NCC_ASSERT_SAME(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("%m: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define NCC_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("%m: next-cycle check failed");

`endif

>>> rtl/core/ncc_pkg.sv
package ncc_pkg;

	localparam int CH_W     = 16;
	localparam int NUM_CH   = 4;
	localparam int ENTRY_W  = CH_W * NUM_CH;
	localparam int NUM_REFS = 6;
	localparam int NUM_COST = 5;

	localparam logic KIND_LOAD     = 1'b0;
	localparam logic KIND_CLASSIFY = 1'b1;

	localparam logic [2:0] CLS_WHITE = 3'd0;
	localparam logic [2:0] CLS_RED   = 3'd1;
	localparam logic [2:0] CLS_GREEN = 3'd2;
	localparam logic [2:0] CLS_BLUE  = 3'd3;
	localparam logic [2:0] CLS_BLACK = 3'd4;
	localparam logic [2:0] CLS_NONE  = 3'd5;
	localparam logic [2:0] CLS_ERROR = 3'd6;

	typedef logic [CH_W-1:0] chan_t;
	typedef chan_t [NUM_CH-1:0] chans_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

	typedef struct packed {
		logic [2:0] cls;
		chan_t      cost;
	} cand_t;

	function automatic chan_t abs_diff(chan_t a, chan_t b);
		return (a >= b) ? chan_t'(a - b) : chan_t'(b - a);
	endfunction

endpackage

>>> rtl/core/nearest_reference_color_classifier.sv
// Nearest reference color classifier.
// Input stream (s_*): one transfer is either a reference load (s_tuser = 0) or a
// classify request (s_tuser = 1). Loads write one 64-bit reference entry for the
// addressed sensor and class and produce no output; loads with a sensor index at
// or beyond SENSOR_COUNT or a class code above five are dropped.
// Output stream (m_*): one transfer per classify request, carrying the winning
// class and the L1 costs to the white, red, green, blue and black references.
// A request with profile_valid low or an out-of-range sensor returns the error
// class with all costs zero.
// Pipeline: five register stages (reference RAM read, channel differences,
// four-term sum, pairwise compare, final compare). One item is taken per cycle
// while no stage is stalled.
// Throughput is one item per clock; each class has its own reference RAM.
// Stalls: each stage holds while the stage after it is full and stalled, so
// bubbles collapse and input is taken while a finished result waits on m_tready.
// A load is written at its transfer edge, so a request right behind it sees it.
// Reset: arst_n clears all stage valid bits and profile_valid; reference
// contents are undefined until loaded.
module nearest_reference_color_classifier import ncc_pkg::*; #(
	parameter int SENSOR_COUNT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// profile_valid register write
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// sensor[7:0], reference_class[10:8], red_level[26:11], green_level[42:27],
	// blue_level[58:43], clear_level[74:59], zero[79:75]
	input  logic [79:0] s_tdata,
	// kind[0]
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// color_class[2:0], cost_white[18:3], cost_red[34:19], cost_green[50:35],
	// cost_blue[66:51], cost_black[82:67], zero[87:83]
	output logic [87:0] m_tdata
);

	localparam int AW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

	logic             profile_valid_q;
	stage_en_t        en;
	logic             accept;
	logic             in_range;
	logic [7:0]       sensor;
	logic [2:0]       ref_cls;
	chans_t           chans_in;
	logic [AW-1:0]    addr;

	logic             valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic             err_s1, err_s2, err_s3;
	chans_t           chans_s1;
	logic [ENTRY_W-1:0] entry_s1 [NUM_REFS];
	chan_t            dist_s3 [NUM_REFS];
	logic [2:0]       cls_s5;
	chan_t            cost_s5 [NUM_COST];

	// unpack the input payload
	assign sensor      = s_tdata[7:0];
	assign ref_cls     = s_tdata[10:8];
	assign chans_in[0] = s_tdata[26:11];
	assign chans_in[1] = s_tdata[42:27];
	assign chans_in[2] = s_tdata[58:43];
	assign chans_in[3] = s_tdata[74:59];
	assign addr        = sensor[AW-1:0];
	assign in_range    = (9'(sensor) < 9'(SENSOR_COUNT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			profile_valid_q <= 1'b0;
		end else if (cfg_we) begin
			profile_valid_q <= cfg_wdata;
		end
	end

	// A stage advances when it is empty or its successor advances.
	assign en.s5    = !valid_s5 || m_tready;
	assign en.s4    = !valid_s4 || en.s5;
	assign en.s3    = !valid_s3 || en.s4;
	assign en.s2    = !valid_s2 || en.s3;
	assign en.s1    = !valid_s1 || en.s2;
	assign s_tready = en.s1;
	assign accept   = s_tvalid && s_tready;

	// one reference RAM per class, all read at the request's sensor
	for (genvar k = 0; k < NUM_REFS; k++) begin : g_ref
		logic we;
		assign we = accept && (s_tuser[0] == KIND_LOAD) && in_range
			&& (ref_cls == 3'(k));
		ncc_ram #(
			.WIDTH (ENTRY_W),
			.DEPTH (SENSOR_COUNT)
		) u_ram (
			.clk   (clk),
			.we    (we),
			.waddr (addr),
			.wdata ({chans_in[3], chans_in[2], chans_in[1], chans_in[0]}),
			.re    (en.s1),
			.raddr (addr),
			.rdata (entry_s1[k])
		);

		ncc_dist u_dist (
			.clk        (clk),
			.en         (en),
			.reading_s1 (chans_s1),
			.entry_s1   (entry_s1[k]),
			.dist_s3    (dist_s3[k])
		);
	end

	// Valid bits; loads leave a bubble since they give no result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= accept && (s_tuser[0] == KIND_CLASSIFY);
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
			if (en.s5) valid_s5 <= valid_s4;
		end
	end

	// reading and error flag travel alongside the RAM read
	always_ff @(posedge clk) begin
		if (en.s1) begin
			chans_s1 <= chans_in;
			err_s1   <= !profile_valid_q || !in_range;
		end
		if (en.s2) err_s2 <= err_s1;
		if (en.s3) err_s3 <= err_s2;
	end

	ncc_select u_select (
		.clk     (clk),
		.en      (en),
		.dist_s3 (dist_s3),
		.err_s3  (err_s3),
		.cls_s5  (cls_s5),
		.cost_s5 (cost_s5)
	);

	assign m_tvalid = valid_s5;
	assign m_tdata  = {5'b0, cost_s5[4], cost_s5[3], cost_s5[2], cost_s5[1], cost_s5[0],
		cls_s5};

endmodule

>>> rtl/core/ncc_ram.sv
module ncc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]      wdata,
	input  logic                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read; hold on stall
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/core/ncc_dist.sv
module ncc_dist import ncc_pkg::*; (
	input  logic                 clk,
	input  stage_en_t            en,
	input  chans_t               reading_s1,
	input  logic [ENTRY_W-1:0]   entry_s1,
	output chan_t                dist_s3
);

	chans_t diff_s2;

	// per-channel absolute difference
	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int c = 0; c < NUM_CH; c++) begin
				diff_s2[c] <= abs_diff(reading_s1[c], entry_s1[c*CH_W +: CH_W]);
			end
		end
	end

	// four-term sum, wrapped to the channel width
	always_ff @(posedge clk) begin
		if (en.s3) begin
			dist_s3 <= chan_t'(diff_s2[0] + diff_s2[1] + diff_s2[2] + diff_s2[3]);
		end
	end

endmodule

>>> rtl/core/ncc_select.sv
module ncc_select import ncc_pkg::*; (
	input  logic       clk,
	input  stage_en_t  en,
	input  chan_t      dist_s3 [NUM_REFS],
	input  logic       err_s3,
	output logic [2:0] cls_s5,
	output chan_t      cost_s5 [NUM_COST]
);

	cand_t pair_s4 [3];
	chan_t cost_s4 [NUM_COST];
	logic  err_s4;
	cand_t ab;
	cand_t fin;

	// Pairs keep tie priority: no paper, white, red, green, blue, black.
	always_ff @(posedge clk) begin
		if (en.s4) begin
			pair_s4[0] <= (dist_s3[CLS_WHITE] < dist_s3[CLS_NONE])
				? cand_t'{cls: CLS_WHITE, cost: dist_s3[CLS_WHITE]}
				: cand_t'{cls: CLS_NONE, cost: dist_s3[CLS_NONE]};
			pair_s4[1] <= (dist_s3[CLS_GREEN] < dist_s3[CLS_RED])
				? cand_t'{cls: CLS_GREEN, cost: dist_s3[CLS_GREEN]}
				: cand_t'{cls: CLS_RED, cost: dist_s3[CLS_RED]};
			pair_s4[2] <= (dist_s3[CLS_BLACK] < dist_s3[CLS_BLUE])
				? cand_t'{cls: CLS_BLACK, cost: dist_s3[CLS_BLACK]}
				: cand_t'{cls: CLS_BLUE, cost: dist_s3[CLS_BLUE]};
			for (int k = 0; k < NUM_COST; k++) begin
				cost_s4[k] <= dist_s3[k];
			end
			err_s4 <= err_s3;
		end
	end

	assign ab  = (pair_s4[1].cost < pair_s4[0].cost) ? pair_s4[1] : pair_s4[0];
	assign fin = (pair_s4[2].cost < ab.cost) ? pair_s4[2] : ab;

	always_ff @(posedge clk) begin
		if (en.s5) begin
			cls_s5 <= err_s4 ? CLS_ERROR : fin.cls;
			for (int k = 0; k < NUM_COST; k++) begin
				cost_s5[k] <= err_s4 ? '0 : cost_s4[k];
			end
		end
	end

endmodule

>>> rtl/core/ncc_checker.sv
`include "nearest_reference_color_classifier_defines.svh"

module ncc_checker import ncc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [87:0] m_tdata
);

	logic [2:0] cls;
	chan_t      c_white, c_red, c_green, c_blue, c_black;

	assign cls     = m_tdata[2:0];
	assign c_white = m_tdata[18:3];
	assign c_red   = m_tdata[34:19];
	assign c_green = m_tdata[50:35];
	assign c_blue  = m_tdata[66:51];
	assign c_black = m_tdata[82:67];

	`NCC_ASSERT_NEXT(a_hold_stalled, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`NCC_ASSERT_SAME(a_error_zero, m_tvalid && (cls == CLS_ERROR), m_tdata[82:3] == '0)
	`NCC_ASSERT_SAME(a_black_strict, m_tvalid && (cls == CLS_BLACK), (c_black < c_white) && (c_black < c_red) && (c_black < c_green) && (c_black < c_blue))
	`NCC_ASSERT_SAME(a_white_min, m_tvalid && (cls == CLS_WHITE), (c_white <= c_red) && (c_white <= c_green) && (c_white <= c_blue) && (c_white <= c_black))

endmodule

bind nearest_reference_color_classifier ncc_checker u_ncc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> tb/ncc_result_checker.sv
`timescale 1ns / 100ps

module ncc_result_checker import ncc_pkg::*; #(
	parameter int SENSOR_COUNT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [79:0] s_tdata,
	input  logic [0:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [87:0] m_tdata,
	output int          failures,
	output int          pending
);

	// [0] color class (zero extended), [1..5] white, red, green, blue, black costs
	typedef logic [NUM_COST:0][CH_W-1:0] verdict_t;

	logic [ENTRY_W-1:0] reference_bank [NUM_REFS][SENSOR_COUNT];
	logic               profile_ok;
	verdict_t           awaited_verdicts[$];

	initial failures = 0;

	function automatic string field_label(int i);
		case (i)
			0:       return "color_class";
			1:       return "cost_white";
			2:       return "cost_red";
			3:       return "cost_green";
			4:       return "cost_blue";
			default: return "cost_black";
		endcase
	endfunction

	function automatic verdict_t nearest_class(logic [7:0] sensor, logic [ENTRY_W-1:0] reading);
		verdict_t   v;
		chan_t      distance [NUM_REFS];
		chan_t      a, b, best_dist;
		logic [17:0] sum;
		logic [2:0] best;
		v = '0;
		if (!profile_ok || sensor >= SENSOR_COUNT) begin
			v[0] = CH_W'(CLS_ERROR);
			return v;
		end
		for (int k = 0; k < NUM_REFS; k++) begin
			sum = '0;
			for (int c = 0; c < NUM_CH; c++) begin
				a = reading[c*CH_W +: CH_W];
				b = reference_bank[k][sensor][c*CH_W +: CH_W];
				sum += (a >= b) ? 18'(a) - 18'(b) : 18'(b) - 18'(a);
			end
			distance[k] = sum[CH_W-1:0];
		end
		// no-paper is the starting guess; strict less-than keeps the earlier class on ties
		best      = CLS_NONE;
		best_dist = distance[CLS_NONE];
		for (int k = 0; k < NUM_COST; k++) begin
			if (distance[k] < best_dist) begin
				best_dist = distance[k];
				best      = 3'(k);
			end
		end
		v[0] = CH_W'(best);
		for (int k = 0; k < NUM_COST; k++)
			v[k+1] = distance[k];
		return v;
	endfunction

	task automatic report(string msg);
		$display("%0t ns: %s", $time, msg);
		failures++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		verdict_t           got, want;
		logic [7:0]         sensor;
		logic [2:0]         cls;
		logic [ENTRY_W-1:0] levels;
		if (!arst_n) begin
			awaited_verdicts.delete();
			profile_ok = 1'b0;
			pending    = 0;
		end else begin
			sensor = s_tdata[7:0];
			cls    = s_tdata[10:8];
			levels = s_tdata[74:11];
			if (cfg_we)
				profile_ok = cfg_wdata;
			// drain before predict, so a result can never match an item taken at the same edge
			if (m_tvalid && m_tready) begin
				got[0] = CH_W'(m_tdata[2:0]);
				for (int k = 0; k < NUM_COST; k++)
					got[k+1] = m_tdata[3 + CH_W*k +: CH_W];
				if (awaited_verdicts.size() == 0) begin
					report($sformatf("result with nothing awaited: class %0d", got[0]));
				end else begin
					want = awaited_verdicts.pop_front();
					for (int i = 0; i <= NUM_COST; i++)
						if (got[i] !== want[i])
							report($sformatf("%s: got 0x%h, expected 0x%h",
								field_label(i), got[i], want[i]));
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == KIND_LOAD) begin
					if (sensor < SENSOR_COUNT && cls < NUM_REFS)
						reference_bank[cls][sensor] = levels;
				end else begin
					awaited_verdicts.push_back(nearest_class(sensor, levels));
				end
			end
			pending = awaited_verdicts.size();
		end
	end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb import ncc_pkg::*;;

	localparam int SENSORS = 16;
	localparam int LIMIT   = 200000;	// cycles
	localparam int DRAIN   = 8;		// five-stage pipe plus margin

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [87:0] m_tdata;

	int failures;
	int pending;
	int cycle_count = 0;

	// Raised for the final stretch: no input gaps and no output stalls.
	logic calm = 1'b0;

	// What has been loaded, so readings can be aimed near a reference.
	logic [ENTRY_W-1:0] loaded [SENSORS][NUM_REFS];

	nearest_reference_color_classifier #(
		.SENSOR_COUNT(SENSORS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	ncc_result_checker #(
		.SENSOR_COUNT(SENSORS)
	) results (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.failures (failures),
		.pending  (pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Watchdog: stop a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Output back-pressure: ready stretches broken by random stalls, except when calm.
	initial begin
		m_tready = 1'b1;
		forever begin
			repeat ($urandom_range(1, 24)) @(negedge clk);
			if (!calm) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	// Present one item and hold it until the transfer happens.
	task automatic send(logic kind, logic [7:0] sensor, logic [2:0] cls,
			logic [ENTRY_W-1:0] levels);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {5'b0, levels, cls, sensor};
		do
			@(posedge clk);
		while (!s_tready);
		if (kind == KIND_LOAD && sensor < SENSORS && cls < NUM_REFS)
			loaded[sensor][cls] = levels;
	endtask

	// Drop valid to open an input gap; n must be at least one.
	task automatic pause_input(int n);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// Insert a gap with probability odds/8, unless in the calm stretch.
	task automatic maybe_gap(int odds);
		if (!calm && $urandom_range(0, 7) < odds)
			pause_input($urandom_range(1, 14));
	endtask

	// Write profile_valid only once the pipe is empty.
	task automatic set_profile(logic v);
		pause_input(1);
		while (pending != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic chan_t random_level();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			default: return chan_t'($urandom);
		endcase
	endfunction

	function automatic logic [ENTRY_W-1:0] random_entry();
		return {random_level(), random_level(), random_level(), random_level()};
	endfunction

	// One random item. Most are classify requests, many aimed near a stored reference;
	// the rest are reference reloads, dropped loads and out-of-range requests.
	task automatic random_item();
		int                 pick, scale;
		logic [7:0]         sensor;
		logic [2:0]         cls;
		logic [ENTRY_W-1:0] levels;
		chan_t              ch, delta;
		pick   = $urandom_range(0, 99);
		sensor = 8'($urandom_range(0, SENSORS - 1));
		cls    = 3'($urandom_range(0, NUM_REFS - 1));
		if (pick < 15) begin
			// reload; copying a sibling entry sets up ties
			case ($urandom_range(0, 2))
				0:       levels = loaded[sensor][$urandom_range(0, NUM_REFS - 1)];
				default: levels = random_entry();
			endcase
			send(KIND_LOAD, sensor, cls, levels);
		end else if (pick < 20) begin
			// load the block must drop: sensor past the end or class code six or seven
			if ($urandom_range(0, 1))
				sensor = 8'($urandom_range(SENSORS, 255));
			else
				cls = 3'($urandom_range(NUM_REFS, 7));
			send(KIND_LOAD, sensor, cls, random_entry());
		end else if (pick < 28) begin
			send(KIND_CLASSIFY, 8'($urandom_range(SENSORS, 255)), 3'($urandom), random_entry());
		end else begin
			if ($urandom_range(0, 9) < 6) begin
				case ($urandom_range(0, 3))
					0:       scale = 0;
					1:       scale = 15;
					2:       scale = 300;
					default: scale = 5000;
				endcase
				levels = loaded[sensor][cls];
				for (int c = 0; c < NUM_CH; c++) begin
					ch    = levels[c*CH_W +: CH_W];
					delta = chan_t'($urandom_range(0, scale));
					levels[c*CH_W +: CH_W] = $urandom_range(0, 1) ? ch + delta : ch - delta;
				end
			end else begin
				levels = random_entry();
			end
			send(KIND_CLASSIFY, sensor, 3'($urandom), levels);
		end
	endtask

	initial begin
		logic [ENTRY_W-1:0] same, tie_pair, probe;
		int                 odds;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = 1'b0;
		s_tvalid  = 1'b0;
		s_tuser   = '0;
		s_tdata   = '0;
		same      = 64'h1234_5678_9ABC_DEF0;
		tie_pair  = 64'h0123_4567_89AB_CDEF;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Profile not valid: requests answer error, and dropped loads change nothing.
		set_profile(1'b0);
		send(KIND_CLASSIFY, 8'd0, CLS_WHITE, random_entry());
		send(KIND_CLASSIFY, 8'd255, 3'd7, '1);
		send(KIND_LOAD, 8'd16, CLS_WHITE, random_entry());
		send(KIND_LOAD, 8'd255, CLS_NONE, '1);
		send(KIND_LOAD, 8'd3, 3'd6, random_entry());
		send(KIND_LOAD, 8'd3, 3'd7, '1);

		// Fill every reference. Sensor 0: all six equal, so no-paper holds the tie.
		// Sensor 1: white zero, red all ones, rest at mid scale, so distances wrap.
		// Sensor 2: blue and black equal, so blue beats black.
		for (int s = 0; s < SENSORS; s++) begin
			for (int c = 0; c < NUM_REFS; c++) begin
				if (s == 0)
					probe = same;
				else if (s == 1)
					probe = (c == CLS_WHITE) ? '0 : (c == CLS_RED) ? '1 : {NUM_CH{16'h8000}};
				else if (s == 2 && (c == CLS_BLUE || c == CLS_BLACK))
					probe = tie_pair;
				else
					probe = random_entry();
				send(KIND_LOAD, 8'(s), 3'(c), probe);
				maybe_gap(2);
			end
		end

		set_profile(1'b1);
		send(KIND_CLASSIFY, 8'd0, CLS_WHITE, same);
		send(KIND_CLASSIFY, 8'd1, CLS_RED, '1);
		send(KIND_CLASSIFY, 8'd1, CLS_GREEN, '0);
		send(KIND_CLASSIFY, 8'd2, CLS_BLUE, tie_pair);
		send(KIND_CLASSIFY, 8'd15, 3'd7, random_entry());
		send(KIND_CLASSIFY, 8'd16, CLS_BLACK, random_entry());
		send(KIND_CLASSIFY, 8'd255, CLS_NONE, '0);
		// A request right behind a load must see the new entry.
		probe = random_entry();
		send(KIND_LOAD, 8'd5, CLS_WHITE, probe);
		send(KIND_CLASSIFY, 8'd5, CLS_WHITE, probe);

		// Random traffic; gap density changes every 32 items, sometimes none.
		odds = 0;
		for (int i = 0; i < 190; i++) begin
			if (i % 32 == 0) begin
				case ($urandom_range(0, 2))
					0:       odds = 0;
					1:       odds = 2;
					default: odds = 5;
				endcase
			end
			random_item();
			maybe_gap(odds);
		end

		// Profile cleared mid-run: requests error again, loads still land.
		set_profile(1'b0);
		for (int i = 0; i < 20; i++) begin
			random_item();
			maybe_gap(3);
		end

		set_profile(1'b1);
		for (int i = 0; i < 130; i++) begin
			if (i == 70)
				calm = 1'b1;
			random_item();
			maybe_gap(3);
		end

		pause_input(1);
		while (pending != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
